[rtl/core/cab_pkg.sv]
// ----------------------------------------------------------------------------
// cab_pkg
// Shared types, mode codes and arithmetic helpers for the clipped alpha blit.
// ----------------------------------------------------------------------------
package cab_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [7:0]  coord_t;
  typedef logic [31:0] argb_t;
  typedef logic [15:0] caddr_t;
  typedef logic [8:0]  dim_t;

  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_READ  = 2'd1;
  localparam mode_t MODE_PAINT = 2'd2;
  localparam mode_t MODE_FILL  = 2'd3;

  localparam logic [2:0] REG_CANVAS_W = 3'd0;
  localparam logic [2:0] REG_CANVAS_H = 3'd1;
  localparam logic [2:0] REG_PLACE_X  = 3'd2;
  localparam logic [2:0] REG_PLACE_Y  = 3'd3;
  localparam logic [2:0] REG_AREA_W   = 3'd4;
  localparam logic [2:0] REG_AREA_H   = 3'd5;
  localparam logic [2:0] REG_GALPHA   = 3'd6;
  localparam logic [2:0] REG_FILL     = 3'd7;

  localparam int          IDX_W        = 18;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
  localparam int          DIM_LIM      = 511;

  // (v + (v >> 8) + 1) >> 8
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // zero counts as one, above cap counts as cap
  function automatic dim_t clamp_dim(input dim_t v, input dim_t cap);
    if (v == '0) begin
      return dim_t'(1);
    end else if (v > cap) begin
      return cap;
    end
    return v;
  endfunction

endpackage

[rtl/core/cab_in_if.sv]
// ----------------------------------------------------------------------------
// cab_in_if
// Request channel: mode, target coordinates and pixel word.
// ----------------------------------------------------------------------------
interface cab_in_if import cab_pkg::*; ();
  logic   valid;
  logic   ready;
  mode_t  mode;
  coord_t column;
  coord_t row;
  argb_t  pixel;

  modport source (output valid, output mode, output column, output row, output pixel,
                  input ready);
  modport sink   (input valid, input mode, input column, input row, input pixel,
                  output ready);
endinterface

[rtl/core/cab_out_if.sv]
// ----------------------------------------------------------------------------
// cab_out_if
// Result channel: write flag, range flag, canvas address and colour.
// ----------------------------------------------------------------------------
interface cab_out_if import cab_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   written;
  logic   in_range;
  caddr_t canvas_address;
  argb_t  colour;

  modport source (output valid, output written, output in_range, output canvas_address,
                  output colour, input ready);
  modport sink   (input valid, input written, input in_range, input canvas_address,
                  input colour, output ready);
endinterface

[rtl/core/clipped_alpha_blit_top.sv]
// ----------------------------------------------------------------------------
// clipped_alpha_blit_top
// Clipped source-over ARGB blit onto a canvas memory, one 9x9 multiply-add
// unit shared by address, alpha scaling and per-channel blending.
// ----------------------------------------------------------------------------
// Load or clipped beats go straight to write-back; others read the canvas.
// Paint with global alpha below opaque first scales alpha; opaque or skipped
// fill and paint then write back, others blend each colour channel in turn.
// One beat in flight; next beat taken the cycle after the result registers.
// Reset returns control and config registers to their defaults; canvas
// contents undefined until loaded, no clearing pass.
// ----------------------------------------------------------------------------
module clipped_alpha_blit_top import cab_pkg::*; #(
  parameter int CANVAS_WIDTH_MAX  = 256,
  parameter int CANVAS_HEIGHT_MAX = 256,
  parameter int AREA_MAX          = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  cab_in_if.sink      in_beat,
  cab_out_if.source   out_beat
);

  localparam int STORE_WORDS = CANVAS_WIDTH_MAX * CANVAS_HEIGHT_MAX;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int XW          = (AW > IDX_W) ? AW : IDX_W;
  localparam int CW_LIM      = (CANVAS_WIDTH_MAX > DIM_LIM) ? DIM_LIM : CANVAS_WIDTH_MAX;
  localparam int CH_LIM      = (CANVAS_HEIGHT_MAX > DIM_LIM) ? DIM_LIM : CANVAS_HEIGHT_MAX;
  localparam int AR_LIM      = (AREA_MAX > DIM_LIM) ? DIM_LIM : AREA_MAX;
  localparam dim_t CW_CAP    = dim_t'(CW_LIM);
  localparam dim_t CH_CAP    = dim_t'(CH_LIM);
  localparam dim_t AR_CAP    = dim_t'(AR_LIM);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ADDR  = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_AMUL  = 4'd3;
  localparam logic [3:0] ST_ADIV  = 4'd4;
  localparam logic [3:0] ST_SEL   = 4'd5;
  localparam logic [3:0] ST_BMUL0 = 4'd6;
  localparam logic [3:0] ST_BMUL1 = 4'd7;
  localparam logic [3:0] ST_BDIV  = 4'd8;
  localparam logic [3:0] ST_WB    = 4'd9;

  // config
  dim_t        cw_r, ch_r, px_r, py_r, aw_r, ah_r;
  logic [7:0]  ga_r;
  argb_t       fill_r;

  // item and datapath
  logic [3:0]  state_r, state_nxt;
  mode_t       mode_r;
  coord_t      col_r, row_r;
  argb_t       pix_r, src_r, res_r, rd_data_r;
  logic        inr_r, wr_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] acc_r;
  logic [7:0]  a_r;
  logic [1:0]  chan_r;

  logic        out_valid_r;
  logic        out_wr_r, out_inr_r;
  caddr_t      out_addr_r;
  argb_t       out_col_r;

  argb_t       mem_r [STORE_WORDS];

  // target decode
  dim_t        w, h, aw, ah;
  logic [9:0]  cx, cy;
  logic        tgt_in, area_out;
  argb_t       src_sel;

  // shared multiply-add
  logic [8:0]       mul_x, mul_y;
  logic [IDX_W-1:0] add_in, mac;

  logic [7:0]  over_ch, under_ch;
  logic        wb_go;
  logic [XW-1:0] idx_wide;
  logic [AW-1:0] mem_addr;

  assign w  = clamp_dim(cw_r, CW_CAP);
  assign h  = clamp_dim(ch_r, CH_CAP);
  assign aw = clamp_dim(aw_r, AR_CAP);
  assign ah = clamp_dim(ah_r, AR_CAP);

  always_comb begin
    area_out = 1'b0;
    if (mode_r == MODE_LOAD || mode_r == MODE_READ) begin
      cx = {2'b00, col_r};
      cy = {2'b00, row_r};
    end else begin
      area_out = ({1'b0, col_r} >= aw) || ({1'b0, row_r} >= ah);
      cx = {px_r[8], px_r} + {2'b00, col_r};
      cy = {py_r[8], py_r} + {2'b00, row_r};
    end
    tgt_in = !area_out && !cx[9] && !cy[9] && (cx[8:0] < w) && (cy[8:0] < h);
  end

  assign src_sel = (mode_r == MODE_PAINT) ? pix_r : fill_r;

  always_comb begin
    case (chan_r)
      2'd2: begin
        over_ch  = src_r[23:16];
        under_ch = rd_data_r[23:16];
      end
      2'd1: begin
        over_ch  = src_r[15:8];
        under_ch = rd_data_r[15:8];
      end
      default: begin
        over_ch  = src_r[7:0];
        under_ch = rd_data_r[7:0];
      end
    endcase
  end

  always_comb begin
    mul_x  = '0;
    mul_y  = '0;
    add_in = '0;
    unique case (state_r)
      ST_ADDR: begin
        mul_x  = cy[8:0];
        mul_y  = w;
        add_in = {{(IDX_W-9){1'b0}}, cx[8:0]};
      end
      ST_AMUL: begin
        mul_x = {1'b0, a_r};
        mul_y = {1'b0, ga_r};
      end
      ST_BMUL0: begin
        mul_x = {1'b0, over_ch};
        mul_y = {1'b0, a_r};
      end
      ST_BMUL1: begin
        mul_x  = {1'b0, under_ch};
        mul_y  = {1'b0, ~a_r};
        add_in = acc_r;
      end
      default: begin
      end
    endcase
  end

  assign mac = mul_x * mul_y + add_in;

  assign wb_go = (state_r == ST_WB) && (!out_valid_r || out_beat.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat.valid) state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        if (!tgt_in || mode_r == MODE_LOAD) state_nxt = ST_WB;
        else                                state_nxt = ST_RD;
      end
      ST_RD: begin
        if (mode_r == MODE_READ)                          state_nxt = ST_WB;
        else if (mode_r == MODE_PAINT && ga_r != 8'hff)   state_nxt = ST_AMUL;
        else                                              state_nxt = ST_SEL;
      end
      ST_AMUL:  state_nxt = ST_ADIV;
      ST_ADIV:  state_nxt = ST_SEL;
      ST_SEL: begin
        if (a_r == 8'd0 || a_r == ALPHA_OPAQUE) state_nxt = ST_WB;
        else                                    state_nxt = ST_BMUL0;
      end
      ST_BMUL0: state_nxt = ST_BMUL1;
      ST_BMUL1: state_nxt = ST_BDIV;
      ST_BDIV: begin
        if (chan_r == 2'd0) state_nxt = ST_WB;
        else                state_nxt = ST_BMUL0;
      end
      ST_WB: begin
        if (wb_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_beat.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cw_r        <= 9'd256;
      ch_r        <= 9'd256;
      px_r        <= '0;
      py_r        <= '0;
      aw_r        <= 9'd256;
      ah_r        <= 9'd256;
      ga_r        <= 8'hff;
      fill_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (wb_go)                out_valid_r <= 1'b1;
      else if (out_beat.ready)  out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CANVAS_W: cw_r   <= cfg_data[8:0];
          REG_CANVAS_H: ch_r   <= cfg_data[8:0];
          REG_PLACE_X:  px_r   <= cfg_data[8:0];
          REG_PLACE_Y:  py_r   <= cfg_data[8:0];
          REG_AREA_W:   aw_r   <= cfg_data[8:0];
          REG_AREA_H:   ah_r   <= cfg_data[8:0];
          REG_GALPHA:   ga_r   <= cfg_data[7:0];
          REG_FILL:     fill_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat.valid) begin
          mode_r <= in_beat.mode;
          col_r  <= in_beat.column;
          row_r  <= in_beat.row;
          pix_r  <= in_beat.pixel;
        end
      end
      ST_ADDR: begin
        inr_r <= tgt_in;
        idx_r <= tgt_in ? mac : '0;
        src_r <= src_sel;
        a_r   <= src_sel[31:24];
        chan_r <= 2'd2;
        wr_r  <= tgt_in && (mode_r == MODE_LOAD);
        res_r <= (tgt_in && mode_r == MODE_LOAD) ? pix_r : '0;
      end
      ST_AMUL:  acc_r <= mac;
      ST_ADIV:  a_r   <= div255(acc_r[15:0]);
      ST_SEL: begin
        if (a_r == ALPHA_OPAQUE) begin
          wr_r  <= 1'b1;
          res_r <= {ALPHA_OPAQUE, src_r[23:0]};
        end else if (a_r != 8'd0) begin
          wr_r  <= 1'b1;
          res_r <= {ALPHA_OPAQUE, 24'd0};
        end
      end
      ST_BMUL0: acc_r <= mac;
      ST_BMUL1: acc_r <= mac;
      ST_BDIV: begin
        case (chan_r)
          2'd2:    res_r[23:16] <= div255(acc_r[15:0]);
          2'd1:    res_r[15:8]  <= div255(acc_r[15:0]);
          default: res_r[7:0]   <= div255(acc_r[15:0]);
        endcase
        chan_r <= chan_r - 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_wr_r   <= wr_r;
      out_inr_r  <= inr_r;
      out_addr_r <= idx_r[15:0];
      out_col_r  <= (inr_r && mode_r == MODE_READ) ? rd_data_r : res_r;
    end
  end

  // canvas memory
  assign idx_wide = XW'(idx_r);
  assign mem_addr = idx_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (wb_go && wr_r) mem_r[mem_addr] <= res_r;
    rd_data_r <= mem_r[mem_addr];
  end

  assign out_beat.valid          = out_valid_r;
  assign out_beat.written        = out_wr_r;
  assign out_beat.in_range       = out_inr_r;
  assign out_beat.canvas_address = out_addr_r;
  assign out_beat.colour         = out_col_r;

endmodule
